>>> design/index_to_radix_digits_macros.svh
// Assertion macros shared by the index_to_radix_digits modules
`ifndef INDEX_TO_RADIX_DIGITS_MACROS_SVH
`define INDEX_TO_RADIX_DIGITS_MACROS_SVH
`ifndef SYNTHESIS
`define ITRD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ITRD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ITRD_ASSERT_IMP(label, ante, cons, msg)
`define ITRD_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

>>> design/itrd_pkg.sv
// Package with types, constants and helpers for index_to_radix_digits
`timescale 1ns / 1ps
`default_nettype none
package itrd_pkg;

    localparam int MAX_DIGITS_DEF  = 64;
    localparam int RADIX_WIDTH_DEF = 16;
    localparam int IDX_W           = 64;
    localparam int HALF_W          = IDX_W / 2;
    localparam int BIT_W           = $clog2(IDX_W);
    localparam int RADIX_REG_W     = 16;
    localparam int COUNT_W         = 7;
    localparam int DIGIT_W         = 16;
    localparam int POS_W           = 6;
    localparam int DATA_W          = 32;
    localparam int ADDR_W          = 3;

    typedef enum logic
    {
        REG_RADIX = 1'b0,
        REG_COUNT = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_PW_LO,
        ST_PW_HI,
        ST_PW_ACC,
        ST_CHECK,
        ST_DIV,
        ST_EMIT,
        ST_EMIT_OOR
    } state_t;

    typedef struct packed
    {
        logic             load;
        logic             mul_lo;
        logic             mul_hi;
        logic             mul_acc;
        logic             div_start;
        logic             div_step;
        logic             emit_digit;
        logic             emit_oor;
        logic             last;
        logic [POS_W-1:0] pos;
    } cmd_t;

    typedef struct packed
    {
        logic in_range;
        logic out_free;
    } sts_t;

    function automatic int radix_store_w(input int w);
        return (w < RADIX_REG_W) ? w : RADIX_REG_W;
    endfunction

endpackage
`default_nettype wire

>>> design/itrd_regs.sv
// Configuration registers with APB-style access and effective-value clamping
`timescale 1ns / 1ps
`default_nettype none
module itrd_regs #(
    parameter int MAX_DIGITS  = itrd_pkg::MAX_DIGITS_DEF,
    parameter int RADIX_WIDTH = itrd_pkg::RADIX_WIDTH_DEF
) (
    input  wire logic                                                  clk,
    input  wire logic                                                  rst_n,
    input  wire logic                                                  psel,
    input  wire logic                                                  penable,
    input  wire logic                                                  pwrite,
    input  wire logic [itrd_pkg::ADDR_W-1:0]                           paddr,
    input  wire logic [itrd_pkg::DATA_W-1:0]                           pwdata,
    output logic      [itrd_pkg::DATA_W-1:0]                           prdata,
    output logic                                                       pready,
    output logic      [itrd_pkg::radix_store_w(RADIX_WIDTH)-1:0]       eff_radix,
    output logic      [itrd_pkg::COUNT_W-1:0]                          eff_count
);
    import itrd_pkg::*;

    localparam int RW = radix_store_w(RADIX_WIDTH);

    logic [RW-1:0]      radix_reg;
    logic [COUNT_W-1:0] count_reg;
    reg_idx_t           sel;

    assign sel    = reg_idx_t'(paddr[ADDR_W-1]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RW'(2);
            count_reg <= COUNT_W'(1);
        end
        else if (psel && penable && pwrite)
        begin
            case (sel)
                REG_RADIX: radix_reg <= pwdata[RW-1:0];
                REG_COUNT: count_reg <= pwdata[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_RADIX: prdata = DATA_W'(radix_reg);
            REG_COUNT: prdata = DATA_W'(count_reg);
            default:   prdata = '0;
        endcase
    end

    assign eff_radix = (radix_reg < RW'(2)) ? RW'(2) : radix_reg;

    always_comb
    begin
        if (count_reg == '0)
            eff_count = COUNT_W'(1);
        else if (count_reg > COUNT_W'(MAX_DIGITS))
            eff_count = COUNT_W'(MAX_DIGITS);
        else
            eff_count = count_reg;
    end

endmodule
`default_nettype wire

>>> design/itrd_ctrl.sv
// Controller state machine sequencing range check, digit divisions and result beats
`timescale 1ns / 1ps
`default_nettype none
`include "index_to_radix_digits_macros.svh"
module itrd_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         tuple_valid,
    output logic                              tuple_ready,
    input  wire logic [itrd_pkg::COUNT_W-1:0] k,
    input  wire itrd_pkg::sts_t               sts,
    output itrd_pkg::cmd_t                    cmd
);
    import itrd_pkg::*;

    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(IDX_W - 1);

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [COUNT_W-1:0] k_m1;

    assign k_m1 = k - COUNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bit_reg   <= bit_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        bit_next    = bit_reg;
        cmd         = '0;
        tuple_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                tuple_ready = 1'b1;
                if (tuple_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_PW_LO;
                end
            end
            ST_PW_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_PW_HI;
            end
            ST_PW_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_PW_ACC;
            end
            ST_PW_ACC:
            begin
                cmd.mul_acc = 1'b1;
                if (cnt_reg == k_m1)
                begin
                    cnt_next   = '0;
                    state_next = ST_CHECK;
                end
                else
                begin
                    cnt_next   = cnt_reg + COUNT_W'(1);
                    state_next = ST_PW_LO;
                end
            end
            ST_CHECK:
            begin
                if (sts.in_range)
                begin
                    cmd.div_start = 1'b1;
                    bit_next      = '0;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_EMIT_OOR;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                bit_next     = bit_reg + BIT_W'(1);
                if (bit_reg == BIT_LAST)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.pos  = cnt_reg[POS_W-1:0];
                cmd.last = (cnt_reg == k_m1);
                if (sts.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (cmd.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next      = cnt_reg + COUNT_W'(1);
                        cmd.div_start = 1'b1;
                        bit_next      = '0;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_EMIT_OOR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_oor = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ITRD_ASSERT_IMP(a_emit_when_free, cmd.emit_digit || cmd.emit_oor, sts.out_free, "beat loaded into a full output register")
    `ITRD_ASSERT_NXT(a_last_to_idle, cmd.emit_digit && cmd.last, state_reg == ST_IDLE, "no return to idle after last digit")
    `ITRD_ASSERT_IMP(a_pos_in_count, cmd.emit_digit, COUNT_W'(cmd.pos) < k, "digit position beyond digit count")

endmodule
`default_nettype wire

>>> design/itrd_datapath.sv
// Datapath: power multiplier, restoring divider and output register
`timescale 1ns / 1ps
`default_nettype none
`include "index_to_radix_digits_macros.svh"
module itrd_datapath #(
    parameter int RADIX_WIDTH = itrd_pkg::RADIX_WIDTH_DEF
) (
    input  wire logic                                            clk,
    input  wire logic                                            rst_n,
    input  wire logic [itrd_pkg::IDX_W-1:0]                      tuple_index,
    input  wire logic [itrd_pkg::radix_store_w(RADIX_WIDTH)-1:0] radix,
    input  wire itrd_pkg::cmd_t                                  cmd,
    output itrd_pkg::sts_t                                       sts,
    output logic                                                 result_valid,
    input  wire logic                                            result_ready,
    output logic      [itrd_pkg::DIGIT_W-1:0]                    digit,
    output logic      [itrd_pkg::POS_W-1:0]                      position,
    output logic                                                 last,
    output logic                                                 out_of_range
);
    import itrd_pkg::*;

    localparam int RW = radix_store_w(RADIX_WIDTH);
    localparam int PW = HALF_W + RW;
    localparam int SW = IDX_W + RW;

    logic [IDX_W-1:0]   q_reg;
    logic [IDX_W-1:0]   p_reg;
    logic [PW-1:0]      mul_reg;
    logic [PW-1:0]      lo_reg;
    logic               sat_reg;
    logic [RW-1:0]      rem_reg;
    logic [DIGIT_W-1:0] digit_reg;
    logic [POS_W-1:0]   position_reg;
    logic               last_reg;
    logic               oor_reg;
    logic               out_valid_reg, out_valid_next;

    logic [HALF_W-1:0]  mul_in;
    logic [PW-1:0]      prod;
    logic [SW-1:0]      sum;
    logic               ovf;
    logic [RW:0]        trial;
    logic [RW:0]        trial_sub;
    logic               ge;

    assign mul_in = cmd.mul_hi ? p_reg[IDX_W-1:HALF_W] : p_reg[HALF_W-1:0];
    assign prod   = PW'(mul_in) * PW'(radix);
    assign sum    = {mul_reg, HALF_W'(0)} + SW'(lo_reg);
    assign ovf    = |sum[SW-1:IDX_W];

    assign trial     = {rem_reg, q_reg[IDX_W-1]};
    assign trial_sub = trial - (RW+1)'(radix);
    assign ge        = (trial >= (RW+1)'(radix));

    assign sts.in_range = sat_reg || (q_reg < p_reg);
    assign sts.out_free = !out_valid_reg || result_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            q_reg   <= tuple_index;
            p_reg   <= IDX_W'(1);
            sat_reg <= 1'b0;
        end
        if (cmd.mul_lo)
            mul_reg <= prod;
        if (cmd.mul_hi)
        begin
            lo_reg  <= mul_reg;
            mul_reg <= prod;
        end
        if (cmd.mul_acc && !sat_reg)
        begin
            if (ovf)
                sat_reg <= 1'b1;
            else
                p_reg <= sum[IDX_W-1:0];
        end
        if (cmd.div_start)
            rem_reg <= '0;
        if (cmd.div_step)
        begin
            rem_reg <= ge ? trial_sub[RW-1:0] : trial[RW-1:0];
            q_reg   <= {q_reg[IDX_W-2:0], ge};
        end
        if (cmd.emit_digit)
        begin
            digit_reg    <= DIGIT_W'(rem_reg);
            position_reg <= cmd.pos;
            last_reg     <= cmd.last;
            oor_reg      <= 1'b0;
        end
        if (cmd.emit_oor)
        begin
            digit_reg    <= '0;
            position_reg <= '0;
            last_reg     <= 1'b1;
            oor_reg      <= 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_digit || cmd.emit_oor)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign result_valid = out_valid_reg;
    assign digit        = digit_reg;
    assign position     = position_reg;
    assign last         = last_reg;
    assign out_of_range = oor_reg;

    `ITRD_ASSERT_NXT(a_oor_beat, cmd.emit_oor, out_valid_reg && oor_reg && last_reg && (digit_reg == '0), "bad out-of-range beat")

endmodule
`default_nettype wire

>>> design/index_to_radix_digits.sv
// Top level: converts a 64-bit tuple index into its base-radix digits
//
// Input channel tuple_valid/tuple_ready carries one 64-bit tuple_index per beat.
// Output channel result_valid/result_ready carries one digit beat per position,
// least significant first, with last set on the final beat of an index. An index
// not below radix^digit_count gives a single beat with out_of_range and last set.
// radix and digit_count are written over the APB-style port; the user must write
// them only while idle, as the block does not enforce it. With k the effective
// digit count, the range check runs k steps of a shared 32-bit-half multiplier;
// each digit then takes one pass of a one-bit-per-cycle restoring divider over
// the 64-bit index and a load of the output register.
// The next index is accepted while the last beat still waits in the output
// register. A stalled receiver holds the divider in its emit step until the
// output register frees. Reset returns the controller to idle, empties the output
// register and sets radix to 2 and digit_count to 1.
`timescale 1ns / 1ps
`default_nettype none
module index_to_radix_digits #(
    parameter int MAX_DIGITS  = itrd_pkg::MAX_DIGITS_DEF,
    parameter int RADIX_WIDTH = itrd_pkg::RADIX_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [itrd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [itrd_pkg::DATA_W-1:0]   pwdata,
    output logic      [itrd_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          tuple_valid,
    output logic                               tuple_ready,
    input  wire logic [itrd_pkg::IDX_W-1:0]    tuple_index,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic      [itrd_pkg::DIGIT_W-1:0]  digit,
    output logic      [itrd_pkg::POS_W-1:0]    position,
    output logic                               last,
    output logic                               out_of_range
);
    import itrd_pkg::*;

    localparam int RW = radix_store_w(RADIX_WIDTH);

    logic [RW-1:0]      eff_radix;
    logic [COUNT_W-1:0] eff_count;
    cmd_t               cmd;
    sts_t               sts;

    itrd_regs #(
        .MAX_DIGITS  (MAX_DIGITS),
        .RADIX_WIDTH (RADIX_WIDTH)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .eff_radix (eff_radix),
        .eff_count (eff_count)
    );

    itrd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .tuple_valid (tuple_valid),
        .tuple_ready (tuple_ready),
        .k           (eff_count),
        .sts         (sts),
        .cmd         (cmd)
    );

    itrd_datapath #(
        .RADIX_WIDTH (RADIX_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .tuple_index  (tuple_index),
        .radix        (eff_radix),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .digit        (digit),
        .position     (position),
        .last         (last),
        .out_of_range (out_of_range)
    );

endmodule
`default_nettype wire

>>> bench/tb_index_to_radix_digits.sv
// Testbench for index_to_radix_digits: directed and random tuple indexes checked per digit beat
`timescale 1ns / 1ps
module tb_index_to_radix_digits;
    import itrd_pkg::*;

    localparam int DIR_N       = 23;
    localparam int RAND_N      = 110;
    localparam int HOLD_AT     = DIR_N + 10;
    localparam int HOLD_CYCLES = 3000;
    localparam int CALM_LO     = DIR_N + 30;
    localparam int CALM_HI     = DIR_N + 70;
    localparam int MAX_CYCLES  = 3_000_000;

    typedef struct packed
    {
        logic [DIGIT_W-1:0] digit;
        logic [POS_W-1:0]   position;
        logic               last;
        logic               out_of_range;
    } digit_beat_t;

    typedef struct
    {
        bit          wr;
        logic [31:0] radix_w;
        logic [31:0] count_w;
        logic [63:0] idx;
        bit          lit;
        logic [15:0] lit_digit;
        bit          lit_oor;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                tuple_valid;
    logic                tuple_ready;
    logic [IDX_W-1:0]    tuple_index;
    logic                result_valid;
    logic                result_ready;
    logic [DIGIT_W-1:0]  digit;
    logic [POS_W-1:0]    position;
    logic                last;
    logic                out_of_range;

    digit_beat_t         expected_digits[$];
    logic [RADIX_REG_W-1:0] radix_reg = 16'd2;
    logic [COUNT_W-1:0]  count_reg = 7'd1;
    int                  items_in = 0;
    int                  errors = 0;
    int                  cycles = 0;
    bit                  held = 1'b0;

    dir_row_t dir_rows [DIR_N] = '{
        '{1'b0, 32'h0, 32'h0, 64'd0, 1'b1, 16'd0, 1'b0},
        '{1'b0, 32'h0, 32'h0, 64'd1, 1'b1, 16'd1, 1'b0},
        '{1'b0, 32'h0, 32'h0, 64'd2, 1'b1, 16'd0, 1'b1},
        '{1'b0, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 16'd0, 1'b1},
        '{1'b1, 32'h0, 32'h0, 64'd1, 1'b1, 16'd1, 1'b0},
        '{1'b0, 32'h0, 32'h0, 64'd2, 1'b1, 16'd0, 1'b1},
        '{1'b1, 32'h1, 32'h1, 64'd0, 1'b1, 16'd0, 1'b0},
        '{1'b1, 32'hFFFF, 32'h1, 64'hFFFE, 1'b1, 16'hFFFE, 1'b0},
        '{1'b0, 32'h0, 32'h0, 64'hFFFF, 1'b1, 16'd0, 1'b1},
        '{1'b1, 32'hABCD_0003, 32'hFFFF_FF81, 64'd2, 1'b1, 16'd2, 1'b0},
        '{1'b0, 32'h0, 32'h0, 64'd3, 1'b1, 16'd0, 1'b1},
        '{1'b1, 32'h2, 32'd64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 16'd0, 1'b0},
        '{1'b0, 32'h0, 32'h0, 64'd0, 1'b0, 16'd0, 1'b0},
        '{1'b0, 32'h0, 32'h0, 64'h5555_5555_AAAA_AAAA, 1'b0, 16'd0, 1'b0},
        '{1'b1, 32'h2, 32'd63, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 16'd0, 1'b0},
        '{1'b0, 32'h0, 32'h0, 64'h8000_0000_0000_0000, 1'b1, 16'd0, 1'b1},
        '{1'b1, 32'hFFFF, 32'd4, 64'hFFFC_0005_FFFC_0000, 1'b0, 16'd0, 1'b0},
        '{1'b0, 32'h0, 32'h0, 64'hFFFC_0005_FFFC_0001, 1'b1, 16'd0, 1'b1},
        '{1'b1, 32'hFFFF, 32'd5, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 16'd0, 1'b0},
        '{1'b1, 32'd10, 32'h83, 64'd999, 1'b0, 16'd0, 1'b0},
        '{1'b0, 32'h0, 32'h0, 64'd1000, 1'b1, 16'd0, 1'b1},
        '{1'b1, 32'd3, 32'd127, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 16'd0, 1'b0},
        '{1'b1, 32'd7, 32'd65, 64'h0123_4567_89AB_CDEF, 1'b0, 16'd0, 1'b0}
    };

    index_to_radix_digits DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .tuple_valid  (tuple_valid),
        .tuple_ready  (tuple_ready),
        .tuple_index  (tuple_index),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .digit        (digit),
        .position     (position),
        .last         (last),
        .out_of_range (out_of_range)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic longint unsigned eff_base();
        return (radix_reg < 2) ? 64'd2 : 64'(radix_reg);
    endfunction

    function automatic int eff_len();
        if (count_reg == 0)
            return 1;
        if (count_reg > MAX_DIGITS_DEF)
            return MAX_DIGITS_DEF;
        return int'(count_reg);
    endfunction

    function automatic void tuple_count(output longint unsigned card, output bit sat);
        longint unsigned r;
        r = eff_base();
        card = 64'd1;
        sat = 1'b0;
        for (int j = 0; j < eff_len(); j++)
        begin
            if (card > 64'hFFFF_FFFF_FFFF_FFFF / r)
            begin
                sat = 1'b1;
                card = '1;
                break;
            end
            card = card * r;
        end
    endfunction

    function automatic void predict_digits(input logic [63:0] idx);
        longint unsigned card;
        longint unsigned q;
        longint unsigned r;
        bit              sat;
        int              k;
        digit_beat_t     b;
        tuple_count(card, sat);
        r = eff_base();
        k = eff_len();
        if (!sat && idx >= card)
        begin
            b = '{digit: '0, position: '0, last: 1'b1, out_of_range: 1'b1};
            expected_digits.push_back(b);
            return;
        end
        q = idx;
        for (int n = 0; n < k; n++)
        begin
            b.digit = DIGIT_W'(q % r);
            b.position = POS_W'(n);
            b.last = (n == k - 1);
            b.out_of_range = 1'b0;
            expected_digits.push_back(b);
            q = q / r;
        end
    endfunction

    function automatic logic [63:0] pick_index();
        longint unsigned card;
        bit              sat;
        logic [63:0]     raw;
        raw = {$urandom, $urandom};
        tuple_count(card, sat);
        if (sat)
            return raw;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return raw % card;
            5:             return card - 64'($urandom_range(0, 1));
            6:             return card + 64'($urandom_range(0, 1000));
            default:       return raw;
        endcase
    endfunction

    function automatic bit calm_window();
        return items_in >= CALM_LO && items_in < CALM_HI;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic reg_write(input reg_idx_t which, input logic [31:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {which, 2'b00};
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (which)
            REG_RADIX: radix_reg = data[RADIX_REG_W-1:0];
            REG_COUNT: count_reg = data[COUNT_W-1:0];
        endcase
    endtask

    task automatic reconfigure(input logic [31:0] rw, input logic [31:0] cw);
        tuple_valid = 1'b0;
        while (expected_digits.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        reg_write(REG_RADIX, rw);
        reg_write(REG_COUNT, cw);
    endtask

    task automatic send_index(input logic [63:0] idx);
        while (!calm_window() && $urandom_range(0, 99) < 28)
        begin
            tuple_valid = 1'b0;
            @(negedge clk);
        end
        tuple_valid = 1'b1;
        tuple_index = idx;
        @(posedge clk);
        while (!tuple_ready)
            @(posedge clk);
        items_in++;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : digit_monitor
        digit_beat_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_digits.size() == 0)
            begin
                $display("%0t ns: unexpected beat, digit %0h position %0d last %0b oor %0b",
                         $time, digit, position, last, out_of_range);
                errors++;
            end
            else
            begin
                want = expected_digits.pop_front();
                check_field("digit", 64'(want.digit), 64'(digit));
                check_field("position", 64'(want.position), 64'(position));
                check_field("last", 64'(want.last), 64'(last));
                check_field("out_of_range", 64'(want.out_of_range), 64'(out_of_range));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("index_to_radix_digits test failed");
            $finish;
        end
    end

    initial
    begin
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && items_in >= HOLD_AT)
            begin
                held = 1'b1;
                result_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            result_ready = calm_window() || ($urandom_range(0, 99) >= 28);
        end
    end

    initial
    begin
        int          n;
        int          k;
        logic [31:0] rw;
        logic [31:0] cw;
        logic [63:0] idx;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tuple_valid = 1'b0;
        tuple_index = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_N; i++)
        begin
            if (dir_rows[i].wr)
                reconfigure(dir_rows[i].radix_w, dir_rows[i].count_w);
            send_index(dir_rows[i].idx);
            if (dir_rows[i].lit)
                expected_digits.push_back('{digit: dir_rows[i].lit_digit, position: '0,
                                            last: 1'b1, out_of_range: dir_rows[i].lit_oor});
            else
                predict_digits(dir_rows[i].idx);
        end

        while (items_in < DIR_N + RAND_N)
        begin
            case ($urandom_range(0, 9))
                0:       rw = {16'($urandom), 16'($urandom_range(0, 1))};
                1:       rw = {16'($urandom), 16'hFFFF};
                2, 3, 4, 5: rw = {16'($urandom), 16'($urandom_range(2, 16))};
                6, 7:    rw = $urandom;
                default: rw = {16'($urandom), 16'($urandom_range(2, 300))};
            endcase
            case ($urandom_range(0, 19))
                0:       k = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(65, 127);
                1:       k = $urandom_range(33, 64);
                default: k = $urandom_range(1, 8);
            endcase
            cw = ($urandom & ~32'h7F) | 32'(k);
            reconfigure(rw, cw);
            n = (eff_len() > 16) ? $urandom_range(1, 3) : $urandom_range(6, 16);
            repeat (n)
            begin
                idx = pick_index();
                send_index(idx);
                predict_digits(idx);
            end
        end

        tuple_valid = 1'b0;
        while (expected_digits.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (errors == 0)
            $display("index_to_radix_digits test passed");
        else
            $display("index_to_radix_digits test failed");
        $finish;
    end

endmodule
